@@ src/prrs_pkg.sv @@
// Package: shared types, constants and codes for the request scheduler.
package prrs_pkg;

  localparam int Depth     = 16;
  localparam int Levels    = 3;
  localparam int IdxW      = $clog2(Depth);
  localparam int CntW      = $clog2(Depth + 1);
  localparam int PrioW     = 2;
  localparam int ClientW   = 16;
  localparam int EntryW    = 1 + PrioW + ClientW;
  localparam int LevW      = $clog2(Levels);

  localparam logic [2:0] ST_QUEUED    = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_INVALID   = 3'd3;
  localparam logic [2:0] ST_SERVED    = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [0:0] REG_PREFERRED = 1'b0;

  typedef struct packed {
    logic                 op;
    logic                 pool;
    logic [PrioW-1:0]     priority_req;
    logic [ClientW-1:0]   client_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [ClientW-1:0]   served_client;
    logic [PrioW-1:0]     served_priority;
    logic [4:0]           pool_count;
  } out_item_t;

  typedef struct packed {
    logic                 pool;
    logic [PrioW-1:0]     prio;
    logic [ClientW-1:0]   client;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN1,
    S_SCAN2,
    S_SCAN3,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_OUT
  } state_t;

endpackage

@@ src/priority_round_robin_request_scheduler_unit.sv @@
// Top level: two-pool priority scheduler with round robin inside a level.
//
// Usage: transactions enter on in_valid/in_stall carrying an op (enqueue or
// dequeue), a pool, a priority and a client id. Each transaction gives one
// result transaction on out_valid/out_stall: a status, the served client and
// priority, and the number of requests left in the addressed pool.
// Requests live in one 16-entry RAM in arrival order, read through a register.
// A transaction takes up to three passes over the stored entries, one entry
// a cycle, plus a compaction pass that moves each later entry down by one
// in a read state and a write state. The next transaction is taken once the
// scheduler is back in idle, and one transaction is worked on at a time.
// The result waits in an output register; while out_stall is high it holds.
// The next transaction is still taken and worked on meanwhile, and its
// finished result waits until the output register has been freed.
// Reset clears occupancy, pool counts, last-served history and the
// preferred-client register; RAM contents need no clearing since only the
// occupied prefix is ever read.
// The APB port holds preferred_client at address 0; pready is always high.
module priority_round_robin_request_scheduler_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  prrs_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output prrs_pkg::out_item_t        out_data,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [0:0]                 cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  localparam int IdxW = prrs_pkg::IdxW;
  localparam int CntW = prrs_pkg::CntW;
  localparam int CW   = prrs_pkg::ClientW;
  localparam int PW   = prrs_pkg::PrioW;

  prrs_pkg::state_t state_r, state_nxt;

  prrs_pkg::in_item_t  req_r, req_nxt;
  prrs_pkg::out_item_t res_r, res_nxt;
  prrs_pkg::out_item_t wrk_r, wrk_nxt;   // result being built
  logic                out_valid_r, out_valid_nxt;

  logic [CntW-1:0] occ_r, occ_nxt;
  logic [CntW-1:0] pcnt_r [2];
  logic [CntW-1:0] pcnt_nxt [2];
  logic [CW-1:0]   last_r [prrs_pkg::Levels];
  logic [CW-1:0]   last_nxt [prrs_pkg::Levels];
  logic [CW-1:0]   pref_r;

  // scan bookkeeping
  logic [CntW-1:0] rd_i_r, rd_i_nxt;     // next address to read
  logic            rd_v_r, rd_v_nxt;     // rdata valid this cycle
  logic [CntW-1:0] at_i_r, at_i_nxt;     // index of rdata
  logic            hit_r, hit_nxt;       // dup found / any found
  logic [PW-1:0]   top_r, top_nxt;
  logic [CW-1:0]   first_r, first_nxt;
  logic [CW-1:0]   next_r, next_nxt;
  logic            prefok_r, prefok_nxt;
  logic            lastok_r, lastok_nxt;
  logic [CW-1:0]   served_r, served_nxt;
  logic [CntW-1:0] pos_r, pos_nxt;
  logic            posok_r, posok_nxt;

  // RAM port
  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  prrs_pkg::entry_t     wdata, rdata;

  prrs_ram #(.Width(prrs_pkg::EntryW), .Depth(prrs_pkg::Depth)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == prrs_pkg::REG_PREFERRED) ? {16'd0, pref_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pref_r <= '0;
    end else if (cfg_wr && cfg_paddr == prrs_pkg::REG_PREFERRED) begin
      pref_r <= cfg_pwdata[CW-1:0];
    end
  end

  assign in_stall  = (state_r != prrs_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  logic [PW-1:0] lvl_idx;
  logic [CW-1:0] last_cur;
  logic          match;
  assign lvl_idx  = (top_r < PW'(prrs_pkg::Levels)) ? top_r : '0;
  assign last_cur = last_r[lvl_idx[prrs_pkg::LevW-1:0]];
  assign match    = rdata.pool == req_r.pool && rdata.prio == top_r;

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    wrk_nxt       = wrk_r;
    out_valid_nxt = out_valid_r;
    occ_nxt       = occ_r;
    pcnt_nxt      = pcnt_r;
    last_nxt      = last_r;
    rd_i_nxt      = rd_i_r;
    rd_v_nxt      = 1'b0;
    at_i_nxt      = rd_i_r;
    hit_nxt       = hit_r;
    top_nxt       = top_r;
    first_nxt     = first_r;
    next_nxt      = next_r;
    prefok_nxt    = prefok_r;
    lastok_nxt    = lastok_r;
    served_nxt    = served_r;
    pos_nxt       = pos_r;
    posok_nxt     = posok_r;
    we            = 1'b0;
    waddr         = occ_r[IdxW-1:0];
    wdata         = '0;
    raddr         = rd_i_r[IdxW-1:0];

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      prrs_pkg::S_IDLE: begin
        if (in_valid) begin
          req_nxt  = in_data;
          rd_i_nxt = '0;
          hit_nxt  = 1'b0;
          top_nxt  = '0;
          first_nxt = '0;
          next_nxt  = '0;
          prefok_nxt = 1'b0;
          lastok_nxt = 1'b0;
          posok_nxt  = 1'b0;
          state_nxt  = prrs_pkg::S_SCAN1;
        end
      end
      // pass 1: duplicate check (enqueue) or top level (dequeue)
      prrs_pkg::S_SCAN1: begin
        if (rd_v_r) begin
          if (req_r.op == prrs_pkg::OP_ENQ) begin
            if (rdata.client == req_r.client_id) hit_nxt = 1'b1;
          end else if (rdata.pool == req_r.pool && (!hit_r || rdata.prio > top_r)) begin
            hit_nxt = 1'b1;
            top_nxt = rdata.prio;
          end
        end
        if (rd_i_r < occ_r) begin
          rd_v_nxt = 1'b1;
          rd_i_nxt = rd_i_r + 1'b1;
        end else if (!rd_v_r) begin
          wrk_nxt.served_client   = '0;
          wrk_nxt.served_priority = '0;
          if (req_r.op == prrs_pkg::OP_ENQ) begin
            state_nxt = prrs_pkg::S_OUT;
            if (req_r.client_id == '0 || req_r.priority_req >= PW'(prrs_pkg::Levels))
              wrk_nxt.status = prrs_pkg::ST_INVALID;
            else if (hit_r)
              wrk_nxt.status = prrs_pkg::ST_DUPLICATE;
            else if (occ_r >= CntW'(prrs_pkg::Depth))
              wrk_nxt.status = prrs_pkg::ST_FULL;
            else begin
              wrk_nxt.status = prrs_pkg::ST_QUEUED;
              state_nxt      = prrs_pkg::S_WRITE;
            end
          end else if (!hit_r) begin
            wrk_nxt.status = prrs_pkg::ST_EMPTY;
            state_nxt      = prrs_pkg::S_OUT;
          end else begin
            rd_i_nxt  = '0;
            state_nxt = prrs_pkg::S_SCAN2;
          end
        end
      end
      // pass 2: candidates at the top level
      prrs_pkg::S_SCAN2: begin
        if (rd_v_r && match) begin
          if (first_r == '0) first_nxt = rdata.client;
          if (pref_r != '0 && rdata.client == pref_r) prefok_nxt = 1'b1;
          if (last_cur != '0 && rdata.client == last_cur) lastok_nxt = 1'b1;
          if (rdata.client > last_cur && (next_r == '0 || rdata.client < next_r))
            next_nxt = rdata.client;
        end
        if (rd_i_r < occ_r) begin
          rd_v_nxt = 1'b1;
          rd_i_nxt = rd_i_r + 1'b1;
        end else if (!rd_v_r) begin
          if (lastok_r && next_r != '0) served_nxt = next_r;
          else if (prefok_r)            served_nxt = pref_r;
          else                          served_nxt = first_r;
          rd_i_nxt  = '0;
          state_nxt = prrs_pkg::S_SCAN3;
        end
      end
      // pass 3: locate the served entry
      prrs_pkg::S_SCAN3: begin
        if (rd_v_r && !posok_r && match && rdata.client == served_r) begin
          posok_nxt = 1'b1;
          pos_nxt   = at_i_r;
        end
        if (rd_i_r < occ_r) begin
          rd_v_nxt = 1'b1;
          rd_i_nxt = rd_i_r + 1'b1;
        end else if (!rd_v_r) begin
          wrk_nxt.served_client   = '0;
          wrk_nxt.served_priority = '0;
          if (posok_r) begin
            rd_i_nxt  = pos_r + 1'b1;
            state_nxt = prrs_pkg::S_SHIFT_RD;
          end else begin
            wrk_nxt.status = prrs_pkg::ST_EMPTY;
            state_nxt      = prrs_pkg::S_OUT;
          end
        end
      end
      // compaction: move entry i+1 down to i
      prrs_pkg::S_SHIFT_RD: begin
        if (rd_i_r < occ_r) begin
          rd_v_nxt  = 1'b1;
          state_nxt = prrs_pkg::S_SHIFT_WR;
        end else begin
          occ_nxt = occ_r - 1'b1;
          if (pcnt_r[req_r.pool] != '0)
            pcnt_nxt[req_r.pool] = pcnt_r[req_r.pool] - 1'b1;
          last_nxt[lvl_idx[prrs_pkg::LevW-1:0]] = served_r;
          wrk_nxt.status          = prrs_pkg::ST_SERVED;
          wrk_nxt.served_client   = served_r;
          wrk_nxt.served_priority = top_r;
          state_nxt               = prrs_pkg::S_OUT;
        end
      end
      prrs_pkg::S_SHIFT_WR: begin
        we        = 1'b1;
        waddr     = IdxW'(at_i_r - 1'b1);
        wdata     = rdata;
        rd_i_nxt  = rd_i_r + 1'b1;
        state_nxt = prrs_pkg::S_SHIFT_RD;
      end
      prrs_pkg::S_WRITE: begin
        we           = 1'b1;
        waddr        = occ_r[IdxW-1:0];
        wdata.pool   = req_r.pool;
        wdata.prio   = req_r.priority_req;
        wdata.client = req_r.client_id;
        occ_nxt      = occ_r + 1'b1;
        pcnt_nxt[req_r.pool] = pcnt_r[req_r.pool] + 1'b1;
        state_nxt    = prrs_pkg::S_OUT;
      end
      // hold the finished result until the output register is free
      prrs_pkg::S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          res_nxt            = wrk_r;
          res_nxt.pool_count = 5'(pcnt_r[req_r.pool]);
          out_valid_nxt      = 1'b1;
          state_nxt          = prrs_pkg::S_IDLE;
        end
      end
      default: state_nxt = prrs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= prrs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
      pcnt_r[0]   <= '0;
      pcnt_r[1]   <= '0;
      for (int k = 0; k < prrs_pkg::Levels; k++) last_r[k] <= '0;
      rd_v_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      occ_r       <= occ_nxt;
      pcnt_r      <= pcnt_nxt;
      last_r      <= last_nxt;
      rd_v_r      <= rd_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    res_r    <= res_nxt;
    wrk_r    <= wrk_nxt;
    rd_i_r   <= rd_i_nxt;
    at_i_r   <= at_i_nxt;
    hit_r    <= hit_nxt;
    top_r    <= top_nxt;
    first_r  <= first_nxt;
    next_r   <= next_nxt;
    prefok_r <= prefok_nxt;
    lastok_r <= lastok_nxt;
    served_r <= served_nxt;
    pos_r    <= pos_nxt;
    posok_r  <= posok_nxt;
  end

  // occupancy is the sum of both pool counts and never exceeds the store
  a_occ_sum: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == pcnt_r[0] + pcnt_r[1]) else $error("occupancy mismatch");
  a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(prrs_pkg::Depth)) else $error("occupancy overflow");
  a_served_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == prrs_pkg::ST_SERVED |-> out_data.served_client != '0)
    else $error("served client zero");
  a_one_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == prrs_pkg::S_OUT) else $error("stray result");

endmodule

@@ src/prrs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module prrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ tb/prrs_checker.sv @@
// Checker: watches both channels and the APB port, predicts and compares results.
`timescale 1ns / 1ps
module prrs_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  prrs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  prrs_pkg::out_item_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [0:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  input  logic                cfg_pready,
  output int                  fail_count,
  output int                  pending
);

  // Scheduler state as predicted here
  logic                         q_pool   [prrs_pkg::Depth];
  logic [prrs_pkg::PrioW-1:0]   q_prio   [prrs_pkg::Depth];
  logic [prrs_pkg::ClientW-1:0] q_client [prrs_pkg::Depth];
  int                           q_occ;
  int                           q_pool_cnt [2];
  logic [prrs_pkg::ClientW-1:0] q_last   [prrs_pkg::Levels];
  logic [prrs_pkg::ClientW-1:0] q_pref;

  prrs_pkg::out_item_t expected_results [$];

  function automatic prrs_pkg::out_item_t schedule(prrs_pkg::in_item_t x);
    prrs_pkg::out_item_t          r;
    bit                           any, last_found, pref_found;
    int                           top, pos;
    logic [prrs_pkg::ClientW-1:0] first, nxt, last, served;
    r = '0;
    served = '0;
    if (x.op == prrs_pkg::OP_ENQ) begin
      if (x.client_id == 0 || x.priority_req >= prrs_pkg::Levels) begin
        r.status = prrs_pkg::ST_INVALID;
      end else begin
        r.status = prrs_pkg::ST_QUEUED;
        for (int i = 0; i < q_occ; i++)
          if (q_client[i] == x.client_id) r.status = prrs_pkg::ST_DUPLICATE;
        if (r.status == prrs_pkg::ST_QUEUED && q_occ >= prrs_pkg::Depth)
          r.status = prrs_pkg::ST_FULL;
        if (r.status == prrs_pkg::ST_QUEUED) begin
          q_pool[q_occ]   = x.pool;
          q_prio[q_occ]   = x.priority_req;
          q_client[q_occ] = x.client_id;
          q_occ++;
          q_pool_cnt[x.pool]++;
        end
      end
    end else begin
      any = 0; top = 0;
      for (int i = 0; i < q_occ; i++)
        if (q_pool[i] == x.pool && (!any || q_prio[i] > top)) begin
          top = q_prio[i];
          any = 1;
        end
      r.status = prrs_pkg::ST_EMPTY;
      if (any) begin
        last = q_last[top];
        first = '0; nxt = '0; last_found = 0; pref_found = 0;
        for (int i = 0; i < q_occ; i++) begin
          if (q_pool[i] == x.pool && q_prio[i] == top) begin
            if (first == 0) first = q_client[i];
            if (q_pref != 0 && q_client[i] == q_pref) pref_found = 1;
            if (last != 0 && q_client[i] == last) last_found = 1;
            if (q_client[i] > last && (nxt == 0 || q_client[i] < nxt)) nxt = q_client[i];
          end
        end
        if (pref_found) first = q_pref;
        served = (last_found && nxt != 0) ? nxt : first;
        pos = q_occ;
        for (int i = q_occ - 1; i >= 0; i--)
          if (q_pool[i] == x.pool && q_prio[i] == top && q_client[i] == served) pos = i;
        if (pos < q_occ) begin
          // Close the gap left by the served request
          for (int i = pos; i + 1 < q_occ; i++) begin
            q_pool[i]   = q_pool[i+1];
            q_prio[i]   = q_prio[i+1];
            q_client[i] = q_client[i+1];
          end
          q_occ--;
          if (q_pool_cnt[x.pool] > 0) q_pool_cnt[x.pool]--;
          q_last[top] = served;
          r.served_client   = served;
          r.served_priority = top[prrs_pkg::PrioW-1:0];
          r.status          = prrs_pkg::ST_SERVED;
        end
      end
    end
    r.pool_count = q_pool_cnt[x.pool][4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    prrs_pkg::out_item_t e;
    if (!rst_n) begin
      q_occ = 0;
      q_pool_cnt[0] = 0;
      q_pool_cnt[1] = 0;
      for (int l = 0; l < prrs_pkg::Levels; l++) q_last[l] = '0;
      q_pref = '0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_data.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_data.status);
            fail_count++;
          end
          if (out_data.served_client !== e.served_client) begin
            $display("%0t: served_client expected %0d actual %0d", $time,
                     e.served_client, out_data.served_client);
            fail_count++;
          end
          if (out_data.served_priority !== e.served_priority) begin
            $display("%0t: served_priority expected %0d actual %0d", $time,
                     e.served_priority, out_data.served_priority);
            fail_count++;
          end
          if (out_data.pool_count !== e.pool_count) begin
            $display("%0t: pool_count expected %0d actual %0d", $time,
                     e.pool_count, out_data.pool_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) expected_results.push_back(schedule(in_data));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == prrs_pkg::REG_PREFERRED)
        q_pref = cfg_pwdata[prrs_pkg::ClientW-1:0];
    end
    pending = expected_results.size();
  end

endmodule

@@ tb/priority_round_robin_request_scheduler_unit_tb.sv @@
// Testbench top: clock, reset, stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps
module priority_round_robin_request_scheduler_unit_tb;

  localparam int WatchdogLimit = 5000;  // idle cycles
  localparam int LongHold      = 300;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  prrs_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  prrs_pkg::out_item_t out_data;
  logic                cfg_psel = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite = 1'b0;
  logic [0:0]          cfg_paddr = '0;
  logic [31:0]         cfg_pwdata = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  int                  fail_count;
  int                  pending;

  // Receiver controls: no_idle suppresses random stalls, hold_go asks for one long hold
  bit                  no_idle = 0;
  logic                hold_go = 1'b0;
  logic                hold_done = 1'b0;
  int                  hold_cnt = 0;
  int                  gap_cnt = 0;
  int                  quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  priority_round_robin_request_scheduler_unit i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  prrs_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  // Receiver: hold off for a random gap after each result, or once for a long stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= LongHold;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else if (gap_cnt != 0) begin
      gap_cnt   <= gap_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall) gap_cnt <= no_idle ? 0 : $urandom_range(0, 3);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("priority_round_robin_request_scheduler_unit verification failed");
        $finish;
      end
    end
  end

  // Offer one transaction after a random gap and hold it until taken
  task automatic send_request(logic op, logic pool, logic [prrs_pkg::PrioW-1:0] prio,
                              logic [prrs_pkg::ClientW-1:0] id);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op, pool: pool, priority_req: prio, client_id: id};
    do @(posedge clk); while (in_stall);
  endtask

  // Drain every outstanding result, then write one register over APB
  task automatic write_register(logic [0:0] addr, logic [31:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Mostly a small id set so that duplicates and round robin actually occur
  function automatic logic [prrs_pkg::ClientW-1:0] pick_client();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(1, 12));
    if (r == 7) return 16'($urandom);
    if (r == 8) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    return 16'($urandom_range(1, 40));
  endfunction

  initial begin
    logic [31:0] pref_choices [8];
    logic        op;
    logic [prrs_pkg::PrioW-1:0] prio;
    pref_choices = '{32'h0, 32'hFFFF_FFFF, 32'd3, 32'd7, 32'd1, 32'd12, 32'd5, 32'h0};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejections, empty pools, both extremes of id, fill to full
    send_request(prrs_pkg::OP_DEQ, 1'b0, 2'd0, 16'd0);         // empty pool A
    send_request(prrs_pkg::OP_DEQ, 1'b1, 2'd3, 16'hFFFF);      // empty pool B
    send_request(prrs_pkg::OP_ENQ, 1'b0, 2'd1, 16'd0);         // client zero rejected
    send_request(prrs_pkg::OP_ENQ, 1'b1, 2'd3, 16'd9);         // priority out of range
    send_request(prrs_pkg::OP_ENQ, 1'b1, 2'd2, 16'hFFFF);
    send_request(prrs_pkg::OP_ENQ, 1'b0, 2'd2, 16'hFFFF);      // duplicate across pools
    for (int i = 1; i <= 15; i++)
      send_request(prrs_pkg::OP_ENQ, i[0], 2'(i % 3), 16'(i * 3));
    send_request(prrs_pkg::OP_ENQ, 1'b0, 2'd0, 16'd1000);      // store full
    write_register(prrs_pkg::REG_PREFERRED, 32'd6);
    for (int i = 0; i < 6; i++) send_request(prrs_pkg::OP_DEQ, i[0], 2'd0, 16'd0);
    write_register(1'b1, 32'd9);                      // unmapped address, ignored

    // Random phases, each with its own preferred client and idle mix
    for (int ph = 0; ph < 8; ph++) begin
      write_register(prrs_pkg::REG_PREFERRED, pref_choices[ph]);
      no_idle = (ph == 2);
      for (int n = 0; n < 100; n++) begin
        if (ph == 4 && n == 10) hold_go <= 1'b1;     // stall the receiver while we keep offering
        op   = ($urandom_range(0, 99) < 55) ? prrs_pkg::OP_ENQ : prrs_pkg::OP_DEQ;
        prio = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        send_request(op, 1'($urandom_range(0, 1)), prio, pick_client());
      end
    end
    no_idle = 0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0)
      $display("priority_round_robin_request_scheduler_unit verification clean");
    else
      $display("priority_round_robin_request_scheduler_unit verification failed");
    $finish;
  end

endmodule
